[rtl/wtd_pkg.sv]
// ----------------------------------------------------------------------------
// wtd_pkg
// Shared types and constants of the weighted table draw core.
// ----------------------------------------------------------------------------
package wtd_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int WIDE_W          = 9;     // holds any entry count up to 256
    localparam int WORD_W          = 32;
    localparam int SLOT_W          = 4;
    localparam int ITEM_W          = 8;
    localparam int COUNT_W         = 8;
    localparam int WEIGHT_W        = 16;
    localparam int CFG_W           = 5;
    localparam int SPAN_W          = COUNT_W + 1;

    localparam int IN_DATA_W       = 80;
    localparam int OUT_DATA_W      = 24;

    localparam logic [WORD_W-1:0] MIX_ADD  = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] MIX_MUL1 = 32'h21F0_AAAD;
    localparam logic [WORD_W-1:0] MIX_MUL2 = 32'h735A_2D97;
    localparam int MIX_SHIFT_A = 16;
    localparam int MIX_SHIFT_B = 15;

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_DRAW = 1'b1
    } t_func;

    typedef struct packed {
        logic [ITEM_W-1:0]   item;
        logic [COUNT_W-1:0]  least;
        logic [COUNT_W-1:0]  most;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MOD_W,
        ST_MOD_W_WAIT,
        ST_WALK,
        ST_FETCH,
        ST_MIX1,
        ST_MIX2,
        ST_MOD_C,
        ST_MOD_C_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;        // latch a draw request
        logic load;         // write a table entry
        logic sum;          // accumulate total weight
        logic mod_start;    // launch the modulo unit
        logic mod_sel_span; // divisor is the count span, else total weight
        logic walk;         // cumulative weight search
        logic fetch;        // read the chosen entry
        logic mix1;
        logic mix2;
        logic out_load;     // capture the result
    } t_cmd;

    typedef struct packed {
        logic sum_done;
        logic total_zero;
        logic mod_busy;
        logic walk_done;
    } t_stat;

endpackage

[rtl/wtd_mod.sv]
// ----------------------------------------------------------------------------
// wtd_mod
// Restoring remainder unit: a 32-bit word modulo a divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module wtd_mod #(
    parameter int DIV_W = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wtd_pkg::WORD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]           i_divisor,
    output logic                       o_busy,
    output logic [DIV_W-1:0]           o_rem
);
    import wtd_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_num, n_num;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;

    // The partial remainder stays below the divisor, so the shifted value
    // fits one extra bit.
    assign shifted = {r_rem, r_num[WORD_W-1]};
    assign diff    = shifted - {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WORD_W);
            n_num  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_num = {r_num[WORD_W-2:0], 1'b0};
            if (shifted >= {1'b0, i_divisor}) begin
                n_rem = diff[DIV_W-1:0];
            end else begin
                n_rem = shifted[DIV_W-1:0];
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

[rtl/wtd_ctrl.sv]
// ----------------------------------------------------------------------------
// wtd_ctrl
// Sequencer of loads and of the draw: sum, reduce, walk, mix, reduce, deliver.
// ----------------------------------------------------------------------------
module wtd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_func,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  wtd_pkg::t_stat i_stat,
    output wtd_pkg::t_cmd  o_cmd
);
    import wtd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (t_func'(i_in_func) == FUNC_DRAW) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SUM;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_stat.sum_done) begin
                    n_state = i_stat.total_zero ? ST_OUT : ST_MOD_W;
                end
            end
            ST_MOD_W: begin
                o_cmd.mod_start = 1'b1;
                n_state         = ST_MOD_W_WAIT;
            end
            ST_MOD_W_WAIT: begin
                if (!i_stat.mod_busy) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_MIX1;
            end
            ST_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = ST_MOD_C;
            end
            ST_MOD_C: begin
                o_cmd.mod_start    = 1'b1;
                o_cmd.mod_sel_span = 1'b1;
                n_state            = ST_MOD_C_WAIT;
            end
            ST_MOD_C_WAIT: begin
                if (!i_stat.mod_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // The output register must be free or draining this cycle.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/wtd_dp.sv]
// ----------------------------------------------------------------------------
// wtd_dp
// Datapath: entry table, weight accumulator, cumulative search, mixer and
// the shared remainder unit.
// ----------------------------------------------------------------------------
module wtd_dp #(
    parameter int MAX_ENTRIES = wtd_pkg::DEF_MAX_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wtd_pkg::t_cmd                i_cmd,
    output wtd_pkg::t_stat               o_stat,
    input  logic [wtd_pkg::CFG_W-1:0]    i_entries,
    input  logic [wtd_pkg::SLOT_W-1:0]   i_slot,
    input  wtd_pkg::t_entry              i_entry,
    input  logic [wtd_pkg::WORD_W-1:0]   i_word,
    output logic                         o_found,
    output logic [wtd_pkg::SLOT_W-1:0]   o_slot,
    output logic [wtd_pkg::ITEM_W-1:0]   o_item,
    output logic [wtd_pkg::COUNT_W-1:0]  o_count
);
    import wtd_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = WEIGHT_W + CW;
    localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_ENTRIES);

    t_entry             r_table [MAX_ENTRIES];
    t_entry             r_rd_data;
    logic [AW-1:0]      rd_addr;

    logic [WORD_W-1:0]  r_word;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_idx;
    logic               r_rd_pend;
    logic [AW-1:0]      r_rd_idx;
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      r_cum;
    logic               r_hit;
    logic [AW-1:0]      r_pick;
    logic [ITEM_W-1:0]  r_item;
    logic [COUNT_W-1:0] r_lo;
    logic [COUNT_W-1:0] r_hi;
    logic [SPAN_W-1:0]  r_span;
    logic [WORD_W-1:0]  r_z;
    logic               r_div_sel;
    logic               r_out_found;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [ITEM_W-1:0]  r_out_item;
    logic [COUNT_W-1:0] r_out_count;

    logic [WIDE_W-1:0]  slot_wide;
    logic [WIDE_W-1:0]  cfg_wide;
    logic [WIDE_W-1:0]  n_wide;
    logic [WIDE_W-1:0]  pick_wide;
    logic [TW-1:0]      rd_weight;
    logic [TW-1:0]      cum_next;
    logic               hit_now;
    logic               can_issue;
    logic [WORD_W-1:0]  mix_a;
    logic [WORD_W-1:0]  mix_b;
    logic [WORD_W-1:0]  mix_c;
    logic [WORD_W-1:0]  mix_out;
    logic [TW-1:0]      div_divisor;
    logic [TW-1:0]      div_rem;
    logic               div_busy;

    // Table: one write port for loads, one registered read port.
    assign slot_wide = WIDE_W'(i_slot);
    assign rd_addr   = i_cmd.fetch ? r_pick : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (slot_wide < MAX_WIDE)) begin
            r_table[slot_wide[AW-1:0]] <= i_entry;
        end
        r_rd_data <= r_table[rd_addr];
    end

    // Entry count saturates at the table depth.
    assign cfg_wide  = WIDE_W'(i_entries);
    assign n_wide    = (cfg_wide > MAX_WIDE) ? MAX_WIDE : cfg_wide;
    assign rd_weight = TW'(r_rd_data.weight);
    assign cum_next  = r_cum + rd_weight;
    assign hit_now   = i_cmd.walk && r_rd_pend && !r_hit && (div_rem < cum_next);
    assign can_issue = (r_idx < r_n);

    // splitmix32 step, one multiply per cycle.
    assign mix_a   = r_word + MIX_ADD;
    assign mix_b   = mix_a ^ (mix_a >> MIX_SHIFT_A);
    assign mix_c   = r_z ^ (r_z >> MIX_SHIFT_B);
    assign mix_out = r_z ^ (r_z >> MIX_SHIFT_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_hit     <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.start) begin
                r_idx     <= '0;
                r_rd_pend <= 1'b0;
            end else if (i_cmd.mod_start && !i_cmd.mod_sel_span) begin
                r_idx     <= '0;
                r_rd_pend <= 1'b0;
                r_hit     <= 1'b0;
            end else if (i_cmd.sum) begin
                r_rd_pend <= can_issue;
                if (can_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
            end else if (i_cmd.walk) begin
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                r_rd_pend <= can_issue && !r_hit && !hit_now;
                if (can_issue && !r_hit && !hit_now) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_word  <= i_word;
            r_n     <= n_wide[CW-1:0];
            r_total <= '0;
        end
        if (i_cmd.sum && r_rd_pend) begin
            r_total <= r_total + rd_weight;
        end
        if (i_cmd.mod_start) begin
            r_div_sel <= i_cmd.mod_sel_span;
        end
        if (i_cmd.mod_start && !i_cmd.mod_sel_span) begin
            r_cum  <= '0;
            // Fallback pick is the last entry in use.
            r_pick <= AW'(r_n - CW'(1));
        end
        if ((i_cmd.sum || i_cmd.walk) && can_issue) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.walk && r_rd_pend && !r_hit) begin
            r_cum <= cum_next;
        end
        if (hit_now) begin
            r_pick <= r_rd_idx;
        end
        if (i_cmd.mix1) begin
            r_item <= r_rd_data.item;
            r_lo   <= r_rd_data.least;
            r_hi   <= r_rd_data.most;
            r_z    <= WORD_W'(mix_b * MIX_MUL1);
        end
        if (i_cmd.mix2) begin
            // A reversed range counts as a span of one.
            if (r_hi < r_lo) begin
                r_span <= SPAN_W'(1);
            end else begin
                r_span <= {1'b0, r_hi} - {1'b0, r_lo} + SPAN_W'(1);
            end
            r_z <= WORD_W'(mix_c * MIX_MUL2);
        end
    end

    assign div_divisor = r_div_sel ? TW'(r_span) : r_total;

    wtd_mod #(
        .DIV_W(TW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mod_start),
        .i_dividend(i_cmd.mod_sel_span ? mix_out : r_word),
        .i_divisor (div_divisor),
        .o_busy    (div_busy),
        .o_rem     (div_rem)
    );

    assign pick_wide = WIDE_W'(r_pick);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_total == '0) begin
                r_out_found <= 1'b0;
                r_out_slot  <= '0;
                r_out_item  <= '0;
                r_out_count <= '0;
            end else begin
                r_out_found <= 1'b1;
                r_out_slot  <= pick_wide[SLOT_W-1:0];
                r_out_item  <= r_item;
                r_out_count <= r_lo + div_rem[COUNT_W-1:0];
            end
        end
    end

    assign o_found = r_out_found;
    assign o_slot  = r_out_slot;
    assign o_item  = r_out_item;
    assign o_count = r_out_count;

    assign o_stat.sum_done   = (r_idx == r_n) && !r_rd_pend;
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.mod_busy   = div_busy;
    assign o_stat.walk_done  = r_hit || ((r_idx == r_n) && !r_rd_pend);

endmodule

[rtl/weighted_table_draw_core.sv]
// Results: a load gives no result; a draw raises one result, and a draw whose
// total weight is zero goes from the sum straight to delivering its result.
// Requests: one at a time; the two 32-step remainder passes of the
// shared modulo unit and the two table sweeps set the draw time.
// Reset: synchronous, active low; clears the sequencer, output valid and count.
// ----------------------------------------------------------------------------
// weighted_table_draw_core
// Weighted random pick from a table of entries with a count drawn in range.
// ----------------------------------------------------------------------------
module weighted_table_draw_core #(
    parameter int MAX_ENTRIES = wtd_pkg::DEF_MAX_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wtd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot, item_id, least_count, most_count, entry_weight, random_word, pad
    input  logic [wtd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // chosen_slot, chosen_item, drop_count, pad
    output logic [wtd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // found
    output logic [0:0]                       m_axis_tuser
);
    import wtd_pkg::*;

    logic [CFG_W-1:0]   r_entries;
    t_cmd               cmd;
    t_stat              stat;
    t_entry             in_entry;
    logic               out_found;
    logic [SLOT_W-1:0]  out_slot;
    logic [ITEM_W-1:0]  out_item;
    logic [COUNT_W-1:0] out_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_valid) begin
            r_entries <= i_cfg_data;
        end
    end

    assign in_entry.item   = s_axis_tdata[11:4];
    assign in_entry.least  = s_axis_tdata[19:12];
    assign in_entry.most   = s_axis_tdata[27:20];
    assign in_entry.weight = s_axis_tdata[43:28];

    wtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wtd_dp #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_entries(r_entries),
        .i_slot   (s_axis_tdata[3:0]),
        .i_entry  (in_entry),
        .i_word   (s_axis_tdata[75:44]),
        .o_found  (out_found),
        .o_slot   (out_slot),
        .o_item   (out_item),
        .o_count  (out_count)
    );

    assign m_axis_tdata = {4'b0, out_count, out_item, out_slot};
    assign m_axis_tuser = out_found;

    // A not-found result carries all-zero fields.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero fields");

    // A draw occupies the block: no request is taken in the next cycle.
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("request accepted while a draw is running");

    // A load never raises a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("load produced a result");

    // The sequencer only issues commands away from idle, except load/start.
    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(cmd.sum || cmd.walk || cmd.mod_start || cmd.out_load))
        else $error("datapath command issued while idle");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted table draw core.
// Table loads and draws are queued by the stimulus process and pushed through
// the input stream by a clocked driver. Every accepted load also updates a
// local copy of the table. Each draw adds its expected outcome to a queue, and
// a clocked monitor compares every result against the oldest expected outcome.
// The entry count is changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;
    import wtd_pkg::*;

    localparam int OFS_ITEM   = SLOT_W;
    localparam int OFS_LEAST  = OFS_ITEM + ITEM_W;
    localparam int OFS_MOST   = OFS_LEAST + COUNT_W;
    localparam int OFS_WEIGHT = OFS_MOST + COUNT_W;
    localparam int OFS_WORD   = OFS_WEIGHT + WEIGHT_W;
    localparam int IN_PAD_W   = IN_DATA_W - OFS_WORD - WORD_W;
    localparam int OFS_COUNT  = SLOT_W + ITEM_W;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 500;

    typedef struct {
        t_func               func;
        logic [SLOT_W-1:0]   slot;
        logic [ITEM_W-1:0]   item;
        logic [COUNT_W-1:0]  least;
        logic [COUNT_W-1:0]  most;
        logic [WEIGHT_W-1:0] weight;
        logic [WORD_W-1:0]   word;
    } t_table_req;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [ITEM_W-1:0]   item;
        logic [COUNT_W-1:0]  count;
    } t_draw_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // Local copy of the table and of the entry count.
    logic [ITEM_W-1:0]   tab_item   [DEF_MAX_ENTRIES];
    logic [COUNT_W-1:0]  tab_least  [DEF_MAX_ENTRIES];
    logic [COUNT_W-1:0]  tab_most   [DEF_MAX_ENTRIES];
    logic [WEIGHT_W-1:0] tab_weight [DEF_MAX_ENTRIES];
    int unsigned         table_span = 0;

    t_table_req    pending_reqs[$];
    t_draw_outcome outcomes_due[$];
    logic [CFG_W-1:0] setting_q[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int settings_taken = 0;
    int fault_count    = 0;
    int tx_gap         = 0;
    int rx_gap         = 0;
    int hold_left      = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    bit calm           = 1'b0;

    weighted_table_draw_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Weighted pick over the entries in use, then one splitmix32 step on the
    // same word for the count.
    function automatic t_draw_outcome predict_draw(input logic [WORD_W-1:0] word);
        t_draw_outcome res;
        int unsigned n, total, rem, run, pick, span;
        logic [WORD_W-1:0] z;
        bit hit;
        res = '0;
        n = (table_span > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : table_span;
        total = 0;
        for (int i = 0; i < n; i++) total += 32'(tab_weight[i]);
        if (total == 0) return res;
        rem = word % total;
        pick = n - 1;
        run = 0;
        hit = 1'b0;
        for (int i = 0; i < n; i++) begin
            run += 32'(tab_weight[i]);
            if (!hit && rem < run) begin
                pick = i;
                hit = 1'b1;
            end
        end
        z = word + MIX_ADD;
        z = (z ^ (z >> MIX_SHIFT_A)) * MIX_MUL1;
        z = (z ^ (z >> MIX_SHIFT_B)) * MIX_MUL2;
        z = z ^ (z >> MIX_SHIFT_B);
        // An inverted range collapses to a single value: the least count.
        if (tab_most[pick] < tab_least[pick]) span = 1;
        else span = int'(tab_most[pick]) - int'(tab_least[pick]) + 1;
        res.found = 1'b1;
        res.slot  = SLOT_W'(pick);
        res.item  = tab_item[pick];
        res.count = COUNT_W'(int'(tab_least[pick]) + (z % span));
        return res;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin : tx_driver
        bit took;
        t_table_req nxt;
        logic [SLOT_W-1:0] s;
        took = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (took) begin
                accepted_count++;
                if (s_axis_tuser[0] == FUNC_LOAD) begin
                    s = s_axis_tdata[SLOT_W-1:0];
                    tab_item[s]   = s_axis_tdata[OFS_ITEM +: ITEM_W];
                    tab_least[s]  = s_axis_tdata[OFS_LEAST +: COUNT_W];
                    tab_most[s]   = s_axis_tdata[OFS_MOST +: COUNT_W];
                    tab_weight[s] = s_axis_tdata[OFS_WEIGHT +: WEIGHT_W];
                end else begin
                    outcomes_due.push_back(predict_draw(s_axis_tdata[OFS_WORD +: WORD_W]));
                end
            end
            if (!s_axis_tvalid || took) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    s_axis_tdata <= {{IN_PAD_W{1'b0}}, nxt.word, nxt.weight, nxt.most,
                                     nxt.least, nxt.item, nxt.slot};
                    s_axis_tuser <= nxt.func;
                    s_axis_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin : rx_monitor
        t_draw_outcome want;
        int gap;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcomes_due.size() == 0) begin
                    $error("result arrived with no draw outstanding");
                    fault_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_axis_tuser[0] !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, m_axis_tuser[0]);
                        fault_count++;
                    end
                    if (m_axis_tdata[SLOT_W-1:0] !== want.slot) begin
                        $error("chosen_slot: expected %0d, actual %0d",
                               want.slot, m_axis_tdata[SLOT_W-1:0]);
                        fault_count++;
                    end
                    if (m_axis_tdata[OFS_ITEM +: ITEM_W] !== want.item) begin
                        $error("chosen_item: expected %0d, actual %0d",
                               want.item, m_axis_tdata[OFS_ITEM +: ITEM_W]);
                        fault_count++;
                    end
                    if (m_axis_tdata[OFS_COUNT +: COUNT_W] !== want.count) begin
                        $error("drop_count: expected %0d, actual %0d",
                               want.count, m_axis_tdata[OFS_COUNT +: COUNT_W]);
                        fault_count++;
                    end
                end
            end
            gap = rx_gap;
            if (gap == 0 && !calm && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 8);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                rx_gap <= gap - 1;
            end else begin
                m_axis_tready <= (hold_left == 0);
            end
        end
    end

    // Long receiver hold-off, counted here on request from the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end
    end

    // Entry count writes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            table_span = 32'(i_cfg_data);
            settings_taken++;
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid && setting_q.size() != 0) begin
            i_cfg_data <= setting_q.pop_front();
            i_cfg_valid <= 1'b1;
        end
    end

    task automatic put_load(input int slot, input int item, input int least,
                            input int most, input int weight);
        t_table_req r;
        r.func   = FUNC_LOAD;
        r.slot   = SLOT_W'(slot);
        r.item   = ITEM_W'(item);
        r.least  = COUNT_W'(least);
        r.most   = COUNT_W'(most);
        r.weight = WEIGHT_W'(weight);
        r.word   = $urandom;
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    // A draw carries random junk in the entry fields, which the core ignores.
    task automatic put_draw(input logic [WORD_W-1:0] word);
        t_table_req r;
        r.func   = FUNC_DRAW;
        r.slot   = SLOT_W'($urandom);
        r.item   = ITEM_W'($urandom);
        r.least  = COUNT_W'($urandom);
        r.most   = COUNT_W'($urandom);
        r.weight = WEIGHT_W'($urandom);
        r.word   = word;
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    // Wait until every request is taken and every result is back, then give a
    // trailing load time to finish.
    task automatic settle();
        while (accepted_count != queued_count || outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entries(input int value);
        int target;
        settle();
        target = settings_taken + 1;
        setting_q.push_back(CFG_W'(value));
        while (settings_taken != target) @(posedge i_clk);
    endtask

    initial begin
        int phase_setting[8];
        int ph, k, n, slot, least, most, weight;
        logic [WORD_W-1:0] word;

        phase_setting = '{16, 1, 31, 4, 0, 9, 17, 0};
        phase_setting[7] = $urandom_range(2, 15);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No entries in use: every draw is a miss.
        set_entries(0);
        put_draw('0);
        put_load(0, 0, 0, 255, 65535);
        put_load(1, 255, 255, 255, 1);
        put_load(2, 7, 200, 10, 100);
        put_load(3, 3, 5, 9, 0);
        for (k = 4; k < DEF_MAX_ENTRIES; k++)
            put_load(k, $urandom, $urandom, $urandom, $urandom_range(1, 65535));
        put_draw('1);

        set_entries(16);
        put_draw('0);
        put_draw('1);
        put_draw(32'd65535);

        // Counts above the table size saturate.
        set_entries(31);
        put_draw($urandom);

        // A single entry: inverted range, then zero weight, then restored.
        set_entries(1);
        put_load(0, 8'hA5, 200, 10, 7);
        put_draw($urandom);
        put_load(0, 8'h5A, 1, 2, 0);
        put_draw($urandom);
        put_load(0, 0, 0, 255, 65535);
        put_draw('1);

        for (ph = 0; ph < 8; ph++) begin
            set_entries(phase_setting[ph]);
            if (ph == 7) calm = 1'b1;
            n = (phase_setting[ph] > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : phase_setting[ph];
            for (k = 0; k < 180; k++) begin
                if ($urandom_range(0, 9) < 4) begin
                    if (n > 0 && $urandom_range(0, 1) == 0) slot = $urandom_range(0, n - 1);
                    else slot = $urandom_range(0, DEF_MAX_ENTRIES - 1);
                    case ($urandom_range(0, 7))
                        0, 1:    weight = 0;
                        2, 3:    weight = $urandom_range(1, 15);
                        4:       weight = $urandom_range(16, 4095);
                        5:       weight = 65535;
                        default: weight = $urandom_range(0, 65535);
                    endcase
                    least = $urandom_range(0, 255);
                    case ($urandom_range(0, 3))
                        0:       most = least;
                        1:       begin
                            least = 0;
                            most = 255;
                        end
                        default: most = $urandom_range(0, 255);
                    endcase
                    put_load(slot, $urandom_range(0, 255), least, most, weight);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       word = '0;
                        1:       word = '1;
                        2:       word = $urandom_range(0, 200000);
                        default: word = $urandom;
                    endcase
                    put_draw(word);
                end
            end
            // Stall the output long enough that the core backs up its input.
            if (ph == 2) hold_asked++;
        end

        settle();
        repeat (150) @(posedge i_clk);
        if (fault_count == 0 && outcomes_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
